[rtl/core/mbr_pkg.sv]
// Shared types and constants for the Mandelbrot pixel colouring block.
// Holds the word structs, register indexes and fixed-point limits.
// No dependencies.
`timescale 1ns / 1ps

package mbr_pkg;

    localparam int PIXEL_COL_W    = 9;
    localparam int PIXEL_ROW_W    = 8;
    localparam int ESCAPE_COUNT_W = 7;
    localparam int PIXEL_COLOR_W  = 16;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_ADDR_W     = 2;

    localparam int MAX_ITERATIONS_DEFAULT = 64;
    localparam int SCREEN_COLS_DEFAULT    = 320;
    localparam int SCREEN_ROWS_DEFAULT    = 240;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_STEP    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VIEW_OFFSET_X = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_VIEW_OFFSET_Y = 2'd2;

    localparam logic [31:0] PIXEL_STEP_RESET = 32'd3355443;

    // 4.0 in Q4.28, held at the width of the sum of two scaled squares.
    localparam logic [35:0] ESCAPE_LIMIT = 36'h0_4000_0000;

    localparam logic signed [47:0] SAT_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] SAT_MIN = -48'sh0000_8000_0000;

    typedef struct packed {
        logic [PIXEL_COL_W-1:0] pixel_col;
        logic [PIXEL_ROW_W-1:0] pixel_row;
    } pixel_in_t;

    typedef struct packed {
        logic [ESCAPE_COUNT_W-1:0] escape_count;
        logic [PIXEL_COLOR_W-1:0]  pixel_color;
    } pixel_out_t;

    // Clamp a widened coordinate back into the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/mandelbrot_pixel_color.sv]
// Top level of the Mandelbrot escape-time pixel colouring pipeline.
// Depends on mbr_pkg for word structs, register indexes and saturation.
// Holds the coordinate mapping, the unrolled orbit stages and the palette ROM.
//
//   Port group  Direction  Handshake        Word
//   s_          in         s_valid/s_ready  mbr_pkg::pixel_in_t  (pixel position)
//   m_          out        m_valid/m_ready  mbr_pkg::pixel_out_t (count and colour)
//   cfg_        in         cfg_wr_en only   cfg_addr, cfg_wdata
//
// A word is accepted at the edge that loads the first mapping register, then passes through
// the second mapping register (offset add and saturation), a product register and an orbit
// register per orbit iteration (multiply, then add, saturate and escape test) and the output
// register, which takes the palette lookup.
// One word enters per cycle; the whole pipeline advances together and holds while
// the output register is full and not taken, so nothing is lost or repeated.
// Reset clears the valid bits and loads the register defaults.
`timescale 1ns / 1ps

module mandelbrot_pixel_color #(
    parameter int MAX_ITERATIONS = mbr_pkg::MAX_ITERATIONS_DEFAULT,
    parameter int SCREEN_COLS    = mbr_pkg::SCREEN_COLS_DEFAULT,
    parameter int SCREEN_ROWS    = mbr_pkg::SCREEN_ROWS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [mbr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mbr_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  mbr_pkg::pixel_in_t                 s_data,

    output logic                               m_valid,
    input  logic                               m_ready,
    output mbr_pkg::pixel_out_t                m_data
);

    localparam int CNT_W     = $clog2(MAX_ITERATIONS + 1);
    localparam int HALF_COLS = SCREEN_COLS / 2;
    localparam int HALF_ROWS = SCREEN_ROWS / 2;
    localparam int COL_LOG   = $clog2(SCREEN_COLS);
    localparam int ROW_LOG   = $clog2(SCREEN_ROWS);
    localparam int DX_W = ((mbr_pkg::PIXEL_COL_W > COL_LOG) ? mbr_pkg::PIXEL_COL_W : COL_LOG) + 1;
    localparam int DY_W = ((mbr_pkg::PIXEL_ROW_W > ROW_LOG) ? mbr_pkg::PIXEL_ROW_W : ROW_LOG) + 1;

    typedef struct packed {
        logic signed [31:0] zx;
        logic signed [31:0] zy;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               done;
        logic [CNT_W-1:0]   count;
    } orbit_t;

    typedef struct packed {
        logic [34:0]        sqx;
        logic [34:0]        sqy;
        logic signed [36:0] xy_prod;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               done;
        logic [CNT_W-1:0]   count;
    } prod_t;

    // Configuration registers.
    logic [31:0]        pixel_step_reg;
    logic signed [31:0] view_offset_x_reg;
    logic signed [31:0] view_offset_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_step_reg    <= mbr_pkg::PIXEL_STEP_RESET;
            view_offset_x_reg <= '0;
            view_offset_y_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                mbr_pkg::CFG_PIXEL_STEP:    pixel_step_reg    <= cfg_wdata;
                mbr_pkg::CFG_VIEW_OFFSET_X: view_offset_x_reg <= $signed(cfg_wdata);
                mbr_pkg::CFG_VIEW_OFFSET_Y: view_offset_y_reg <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    logic advance;
    logic out_valid_reg;
    mbr_pkg::pixel_out_t out_reg;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Mapping, first cycle: offset from the screen centre times the pixel step.
    logic signed [DX_W-1:0]  dx;
    logic signed [DY_W-1:0]  dy;
    logic signed [DX_W+32:0] mx_next, mx_reg;
    logic signed [DY_W+32:0] my_next, my_reg;
    logic                    map_valid_reg;

    always_comb begin
        dx = DX_W'($signed({1'b0, s_data.pixel_col})) - DX_W'(HALF_COLS);
        dy = DY_W'($signed({1'b0, s_data.pixel_row})) - DY_W'(HALF_ROWS);
        mx_next = dx * $signed({1'b0, pixel_step_reg});
        my_next = dy * $signed({1'b0, pixel_step_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_valid_reg <= 1'b0;
        end else if (advance) begin
            map_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mx_reg <= mx_next;
            my_reg <= my_next;
        end
    end

    // Orbit state between iterations; entry 0 holds the mapped point with z = c.
    orbit_t orbit_next [MAX_ITERATIONS+1];
    orbit_t orbit_reg  [MAX_ITERATIONS+1];
    logic   orbit_valid_reg [MAX_ITERATIONS+1];
    prod_t  prod_next [MAX_ITERATIONS];
    prod_t  prod_reg  [MAX_ITERATIONS];
    logic   prod_valid_reg [MAX_ITERATIONS];

    always_comb begin
        orbit_next[0].cx    = mbr_pkg::sat32(48'(mx_reg) + 48'(view_offset_x_reg));
        orbit_next[0].cy    = mbr_pkg::sat32(48'(my_reg) + 48'(view_offset_y_reg));
        orbit_next[0].zx    = orbit_next[0].cx;
        orbit_next[0].zy    = orbit_next[0].cy;
        orbit_next[0].done  = 1'b0;
        orbit_next[0].count = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orbit_valid_reg[0] <= 1'b0;
        end else if (advance) begin
            orbit_valid_reg[0] <= map_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            orbit_reg[0] <= orbit_next[0];
        end
    end

    for (genvar i = 0; i < MAX_ITERATIONS; i++) begin : g_iter
        logic signed [63:0] pxx;
        logic signed [63:0] pyy;
        logic signed [63:0] pxy;
        logic        [35:0] mag;

        // Products are scaled back with an arithmetic shift, which floors.
        always_comb begin
            pxx = orbit_reg[i].zx * orbit_reg[i].zx;
            pyy = orbit_reg[i].zy * orbit_reg[i].zy;
            pxy = orbit_reg[i].zx * orbit_reg[i].zy;
            prod_next[i].sqx     = pxx[62:28];
            prod_next[i].sqy     = pyy[62:28];
            prod_next[i].xy_prod = pxy[63:27];
            prod_next[i].cx      = orbit_reg[i].cx;
            prod_next[i].cy      = orbit_reg[i].cy;
            prod_next[i].done    = orbit_reg[i].done;
            prod_next[i].count   = orbit_reg[i].count;
        end

        always_comb begin
            mag = 36'(prod_reg[i].sqx) + 36'(prod_reg[i].sqy);
            orbit_next[i+1].cx = prod_reg[i].cx;
            orbit_next[i+1].cy = prod_reg[i].cy;
            orbit_next[i+1].zy = mbr_pkg::sat32(48'(prod_reg[i].xy_prod) + 48'(prod_reg[i].cy));
            orbit_next[i+1].zx = mbr_pkg::sat32($signed(48'(prod_reg[i].sqx))
                                                - $signed(48'(prod_reg[i].sqy))
                                                + 48'(prod_reg[i].cx));
            orbit_next[i+1].done  = prod_reg[i].done;
            orbit_next[i+1].count = prod_reg[i].count;
            // The first iteration that sees the magnitude beyond 4 fixes the count.
            if (!prod_reg[i].done && (mag > mbr_pkg::ESCAPE_LIMIT)) begin
                orbit_next[i+1].done  = 1'b1;
                orbit_next[i+1].count = CNT_W'(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                prod_valid_reg[i]    <= 1'b0;
                orbit_valid_reg[i+1] <= 1'b0;
            end else if (advance) begin
                prod_valid_reg[i]    <= orbit_valid_reg[i];
                orbit_valid_reg[i+1] <= prod_valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                prod_reg[i]    <= prod_next[i];
                orbit_reg[i+1] <= orbit_next[i+1];
            end
        end
    end

    // Palette ROM, worked out at elaboration; the last entry is black.
    logic [mbr_pkg::PIXEL_COLOR_W-1:0] palette_rom [MAX_ITERATIONS+1];

    for (genvar n = 0; n <= MAX_ITERATIONS; n++) begin : g_palette
        localparam longint unsigned M  = longint'(MAX_ITERATIONS);
        localparam longint unsigned A  = longint'(n);
        localparam longint unsigned D  = M - A;
        localparam longint unsigned M4 = M * M * M * M;
        localparam logic [63:0] R = (64'd2295 * D * A * A * A) / M4;
        localparam logic [63:0] G = (64'd3825 * D * D * A * A) / M4;
        localparam logic [63:0] B = (64'd4335 * D * D * D * A) / (64'd2 * M4);
        localparam logic [15:0] COLOR = (n >= MAX_ITERATIONS) ? 16'h0000
                                        : {R[7:3], G[7:2], B[7:3]};
        assign palette_rom[n] = COLOR;
    end

    logic [CNT_W-1:0]    final_count;
    mbr_pkg::pixel_out_t out_next;

    always_comb begin
        final_count = orbit_reg[MAX_ITERATIONS].done ? orbit_reg[MAX_ITERATIONS].count
                                                     : CNT_W'(MAX_ITERATIONS);
        out_next.escape_count = mbr_pkg::ESCAPE_COUNT_W'(final_count);
        out_next.pixel_color  = palette_rom[final_count];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= orbit_valid_reg[MAX_ITERATIONS];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule

[tb/testbench.sv]
// Self-checking bench for mandelbrot_pixel_color: drives pixel words, predicts escape counts
// and palette colours, and compares every result word. Depends on mbr_pkg and the top level.
`timescale 1ns / 1ps

module testbench;

    localparam int ITER_LIMIT = mbr_pkg::MAX_ITERATIONS_DEFAULT;
    localparam int CENTRE_COL = mbr_pkg::SCREEN_COLS_DEFAULT / 2;
    localparam int CENTRE_ROW = mbr_pkg::SCREEN_ROWS_DEFAULT / 2;
    localparam int FRAC_BITS  = 28;
    localparam longint ESCAPE_BOUND = longint'(1) << 30;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    // Index three is not a register; writes there must leave the view untouched.
    localparam logic [mbr_pkg::CFG_ADDR_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int WORDS_PER_PHASE = 150;
    localparam int VIEW_PHASES     = 9;
    localparam int PIPE_DEPTH      = 2 * ITER_LIMIT + 3;

    class escape_checker;
        bit [31:0] pixel_step;
        int view_offset_x;
        int view_offset_y;
        mbr_pkg::pixel_out_t pending_pixels[$];
        int pixels_in;
        int results_seen;
        int interior_seen;
        int mismatches;

        function new();
            pixel_step    = mbr_pkg::PIXEL_STEP_RESET;
            view_offset_x = 0;
            view_offset_y = 0;
        endfunction

        function void apply_write(logic [mbr_pkg::CFG_ADDR_W-1:0] addr, logic [31:0] data);
            case (addr)
                mbr_pkg::CFG_PIXEL_STEP:    pixel_step = data;
                mbr_pkg::CFG_VIEW_OFFSET_X: view_offset_x = int'(data);
                mbr_pkg::CFG_VIEW_OFFSET_Y: view_offset_y = int'(data);
                default: ;
            endcase
        endfunction

        function longint clamp_q428(longint v);
            if (v > Q_MAX) return Q_MAX;
            if (v < Q_MIN) return Q_MIN;
            return v;
        endfunction

        // Iterates z = z*z + c from z = c; squares are floored, never wrapped.
        function int escape_time(bit [mbr_pkg::PIXEL_COL_W-1:0] col,
                                 bit [mbr_pkg::PIXEL_ROW_W-1:0] row);
            longint cx, cy, zx, zy, zx2, zy2, twice_xy;
            int i;
            cx = clamp_q428((longint'(col) - CENTRE_COL) * longint'(pixel_step)
                            + longint'(view_offset_x));
            cy = clamp_q428((longint'(row) - CENTRE_ROW) * longint'(pixel_step)
                            + longint'(view_offset_y));
            zx = cx;
            zy = cy;
            for (i = 0; i < ITER_LIMIT; i++) begin
                zx2 = (zx * zx) >>> FRAC_BITS;
                zy2 = (zy * zy) >>> FRAC_BITS;
                if (zx2 + zy2 > ESCAPE_BOUND) return i;
                twice_xy = (zx * zy) >>> (FRAC_BITS - 1);
                zy = clamp_q428(twice_xy + cy);
                zx = clamp_q428(zx2 - zy2 + cx);
            end
            return ITER_LIMIT;
        endfunction

        function bit [15:0] palette_entry(int n);
            longint a, d, m4, r, g, b;
            if (n >= ITER_LIMIT) return 16'h0000;
            a  = n;
            d  = ITER_LIMIT - n;
            m4 = longint'(ITER_LIMIT) * ITER_LIMIT * ITER_LIMIT * ITER_LIMIT;
            r  = (longint'(9 * 255) * d * a * a * a) / m4;
            g  = (longint'(15 * 255) * d * d * a * a) / m4;
            b  = (longint'(17 * 255) * d * d * d * a) / (2 * m4);
            return {r[7:3], g[7:2], b[7:3]};
        endfunction

        function void note_pixel(mbr_pkg::pixel_in_t px);
            mbr_pkg::pixel_out_t w;
            int n;
            n = escape_time(px.pixel_col, px.pixel_row);
            w.escape_count = n[mbr_pkg::ESCAPE_COUNT_W-1:0];
            w.pixel_color  = palette_entry(n);
            pending_pixels.push_back(w);
            pixels_in++;
        endfunction

        function void check_result(mbr_pkg::pixel_out_t got);
            mbr_pkg::pixel_out_t want;
            results_seen++;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with none awaited: count %0d colour %h",
                             $time, got.escape_count, got.pixel_color);
                return;
            end
            want = pending_pixels.pop_front();
            if (want.escape_count == ITER_LIMIT) interior_seen++;
            if (got.escape_count !== want.escape_count ||
                    got.pixel_color !== want.pixel_color) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: count %0d colour %h, wanted count %0d colour %h",
                             $time, got.escape_count, got.pixel_color,
                             want.escape_count, want.pixel_color);
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [mbr_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [mbr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    mbr_pkg::pixel_in_t             s_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    mbr_pkg::pixel_out_t            m_data;

    escape_checker sb = new();
    bit steady = 1'b0;
    int stall_left = 0;
    int views_used = 0;

    mandelbrot_pixel_color dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Mostly no pause, some short ones and now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 150);
    endfunction

    function automatic mbr_pkg::pixel_in_t at_pixel(int col, int row);
        mbr_pkg::pixel_in_t px;
        px.pixel_col = col[mbr_pkg::PIXEL_COL_W-1:0];
        px.pixel_row = row[mbr_pkg::PIXEL_ROW_W-1:0];
        return px;
    endfunction

    // Mostly on-screen positions, with a share of the whole field range.
    function automatic mbr_pkg::pixel_in_t any_pixel();
        if ($urandom_range(0, 9) < 8)
            return at_pixel($urandom_range(0, 319), $urandom_range(0, 239));
        return at_pixel($urandom_range(0, 511), $urandom_range(0, 255));
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            stall_left = idle_gap();
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // Called and returns at a falling edge.
    task automatic send_pixel(mbr_pkg::pixel_in_t px);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(px);
        @(negedge aclk);
    endtask

    // Leaves the write enable high so that writes can follow back to back.
    task automatic write_register(logic [mbr_pkg::CFG_ADDR_W-1:0] addr, logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.apply_write(addr, data);
        @(negedge aclk);
    endtask

    task automatic set_view(logic [31:0] step, logic [31:0] ox, logic [31:0] oy);
        write_register(mbr_pkg::CFG_PIXEL_STEP, step);
        write_register(mbr_pkg::CFG_VIEW_OFFSET_X, ox);
        write_register(mbr_pkg::CFG_VIEW_OFFSET_Y, oy);
        write_register(CFG_SPARE_INDEX, $urandom);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        views_used++;
    endtask

    // Every word yields one result, so an empty queue means an empty pipeline.
    task automatic end_phase();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        logic [31:0] step, ox, oy;
        int p;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset view: corners, the origin, the tip at -2, cardioid points and
        // positions beyond the screen edge.
        views_used = 1;
        send_pixel(at_pixel(0, 0));
        send_pixel(at_pixel(160, 120));
        send_pixel(at_pixel(0, 120));
        send_pixel(at_pixel(319, 239));
        send_pixel(at_pixel(511, 255));
        send_pixel(at_pixel(320, 240));
        send_pixel(at_pixel(150, 120));
        send_pixel(at_pixel(130, 120));
        send_pixel(at_pixel(100, 60));
        send_pixel(at_pixel(341, 85));
        send_pixel(at_pixel(170, 170));
        send_pixel(at_pixel(255, 127));
        send_pixel(at_pixel(256, 128));
        send_pixel(at_pixel(200, 40));
        end_phase();

        // Largest step with extreme offsets drives both coordinates into saturation.
        set_view(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_pixel(at_pixel(0, 0));
        send_pixel(at_pixel(511, 255));
        send_pixel(at_pixel(160, 120));
        end_phase();

        // Zero step: every pixel lands on c = -2, whose orbit sits exactly on the limit.
        set_view(32'd0, 32'hE000_0000, 32'd0);
        send_pixel(at_pixel(160, 120));
        send_pixel(at_pixel(7, 200));
        end_phase();

        set_view(32'd0, 32'd0, 32'h2000_0000);
        send_pixel(at_pixel(160, 120));
        send_pixel(at_pixel(300, 10));
        end_phase();

        for (p = 0; p < VIEW_PHASES; p++) begin
            case (p)
                0: begin step = mbr_pkg::PIXEL_STEP_RESET; ox = 0; oy = 0; end
                1: begin step = 32'd209715; ox = -32'sd201326592; oy = 32'd26843546; end
                2: begin step = 32'd13107; ox = -32'sd199607000; oy = 32'd35380000; end
                3: begin step = 32'd13421772; ox = 0; oy = 0; end
                4: begin
                    step = $urandom_range(0, 32'h0400_0000);
                    ox = int'($urandom) >>> 1;
                    oy = int'($urandom) >>> 1;
                end
                5: begin step = 32'hFFFF_FFFF; ox = $urandom; oy = $urandom; end
                6: begin step = 32'd1; ox = -32'sd53687091; oy = 0; end
                7: begin step = $urandom; ox = $urandom; oy = $urandom; end
                default: begin step = mbr_pkg::PIXEL_STEP_RESET; ox = 0; oy = 0; end
            endcase
            steady = (p == VIEW_PHASES - 1) || ($urandom_range(0, 3) == 0);
            set_view(step, ox, oy);
            repeat (WORDS_PER_PHASE) send_pixel(any_pixel());
            end_phase();
        end

        repeat (PIPE_DEPTH + 10) @(negedge aclk);
        $display("testbench: %0d pixel words under %0d view settings, %0d results compared",
                 sb.pixels_in, views_used, sb.results_seen);
        $display("testbench: %0d orbits ran to the iteration limit, %0d mismatches",
                 sb.interior_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
